// ===== src/mit_pkg.sv =====
package mit_pkg;

    localparam int CHANNELS      = 5;
    localparam int CH_W          = 3;
    localparam int TIME_W        = 16;
    localparam int COUNT_W       = 16;
    localparam int DIV_W         = 2;
    localparam int PRE_W         = 3;
    localparam int TICKS_PER_US  = 25;
    localparam int PROD_W        = TIME_W + 8;

    localparam logic [TIME_W-1:0] LIMIT_DIV1 = TIME_W'(2621);
    localparam logic [TIME_W-1:0] LIMIT_DIV2 = TIME_W'(5242);
    localparam logic [TIME_W-1:0] LIMIT_DIV4 = TIME_W'(10485);
    localparam logic [TIME_W-1:0] LIMIT_DIV8 = TIME_W'(20971);

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_SET   = 3'd1,
        ACT_START = 3'd2,
        ACT_STOP  = 3'd3,
        ACT_CLEAR = 3'd4
    } action_t;

    typedef struct packed {
        logic               tick;
        logic               set;
        logic [DIV_W-1:0]   div;
        logic [COUNT_W-1:0] compare;
    } chan_ctrl_t;

    function automatic logic [DIV_W-1:0] pick_divider(input logic [TIME_W-1:0] t);
        logic [DIV_W-1:0] d;
        d = '0;
        if (t > LIMIT_DIV1) d = DIV_W'(1);
        if (t > LIMIT_DIV2) d = DIV_W'(2);
        if (t > LIMIT_DIV4) d = DIV_W'(3);
        return d;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_compare(input logic [TIME_W-1:0] t,
                                                        input logic [DIV_W-1:0] d);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(t) * PROD_W'(TICKS_PER_US);
        return COUNT_W'(prod >> d);
    endfunction

endpackage

// ===== src/mit_channel.sv =====
module mit_channel
    import mit_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chan_ctrl_t ctrl,
    output logic       match
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] compare_reg, compare_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [PRE_W-1:0]   pre_reg, pre_next;
    logic [PRE_W-1:0]   last;

    always_comb begin
        last         = PRE_W'((4'd1 << div_reg) - 4'd1);
        count_next   = count_reg;
        compare_next = compare_reg;
        div_next     = div_reg;
        pre_next     = pre_reg;
        match        = 1'b0;
        if (ctrl.set) begin
            count_next   = '0;
            pre_next     = '0;
            div_next     = ctrl.div;
            compare_next = ctrl.compare;
        end else if (ctrl.tick) begin
            if (pre_reg < last) begin
                pre_next = pre_reg + PRE_W'(1);
            end else begin
                pre_next = '0;
                if (count_reg == compare_reg) begin
                    count_next = '0;
                    match      = 1'b1;
                end else begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            compare_reg <= '1;
            div_reg     <= '0;
            pre_reg     <= '0;
        end else begin
            count_reg   <= count_next;
            compare_reg <= compare_next;
            div_reg     <= div_next;
            pre_reg     <= pre_next;
        end
    end

endmodule

// ===== src/multichannel_interval_timer.sv =====
// Five-channel periodic interval timer. Each input transaction carries one action
// (tick, set period, start, stop, clear flag) and yields exactly one result transaction
// with the set status and the flag and run bits after that action. One transaction is
// taken every clock cycle unless a result waits untaken. A transaction accepted into the
// input register passes through the channel logic and lands in the result register once
// that register is free or the result in it is taken. A waiting result holds the input
// register; the input closes only while both registers are full and the result is not taken.
module multichannel_interval_timer
    import mit_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[2:0], channel[5:3], time_us[21:6], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[0], flags[5:1], running[10:6], zero pad
);

    logic                in_valid_reg;
    logic [2:0]          in_action_reg;
    logic [CH_W-1:0]     in_channel_reg;
    logic [TIME_W-1:0]   in_time_reg;

    logic                out_valid_reg;
    logic                out_status_reg, out_status_next;

    logic [CHANNELS-1:0] run_reg, run_next;
    logic [CHANNELS-1:0] flags_reg, flags_next;
    logic [CHANNELS-1:0] ch_sel;
    logic [CHANNELS-1:0] match_vec;
    logic [CH_W-1:0]     ch;
    logic                advance;
    logic                is_tick;
    logic                is_set;
    logic [DIV_W-1:0]    set_div;
    logic [COUNT_W-1:0]  set_compare;
    chan_ctrl_t          ctrl [CHANNELS];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg  <= s_tdata[2:0];
            in_channel_reg <= s_tdata[5:3];
            in_time_reg    <= s_tdata[21:6];
        end
    end

    assign ch          = (in_channel_reg < CH_W'(CHANNELS)) ? in_channel_reg : '0;
    assign ch_sel      = CHANNELS'(1) << ch;
    assign is_tick     = advance && (in_action_reg == ACT_TICK);
    assign is_set      = advance && (in_action_reg == ACT_SET);
    assign set_div     = pick_divider(in_time_reg);
    assign set_compare = pick_compare(in_time_reg, set_div);

    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        assign ctrl[i].tick    = is_tick && run_reg[i];
        assign ctrl[i].set     = is_set && ch_sel[i];
        assign ctrl[i].div     = set_div;
        assign ctrl[i].compare = set_compare;

        mit_channel u_channel (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl[i]),
            .match   (match_vec[i])
        );
    end

    always_comb begin
        run_next        = run_reg;
        flags_next      = flags_reg;
        out_status_next = 1'b0;
        unique case (in_action_reg)
            ACT_TICK: begin
                flags_next = flags_reg | match_vec;
            end
            ACT_SET: begin
                run_next        = run_reg & ~ch_sel;
                flags_next      = flags_reg & ~ch_sel;
                out_status_next = (in_time_reg == '0) || (in_time_reg > LIMIT_DIV8);
            end
            ACT_START: begin
                run_next = run_reg | ch_sel;
            end
            ACT_STOP: begin
                run_next = run_reg & ~ch_sel;
            end
            ACT_CLEAR: begin
                flags_next = flags_reg & ~ch_sel;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                run_reg   <= run_next;
                flags_reg <= flags_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, run_reg, flags_reg, out_status_reg};

endmodule

// ===== tb/sv/multichannel_interval_timer_checker.sv =====
module multichannel_interval_timer_checker
    import mit_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // action[2:0], channel[5:3], time_us[21:6], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // status[0], flags[5:1], running[10:6], zero pad
    output int          error_count,
    output int          awaited,
    output int          report_count,
    output int          match_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                status;
        logic [CHANNELS-1:0] flags;
        logic [CHANNELS-1:0] running;
    } timer_report_t;

    logic [COUNT_W-1:0]  tick_count     [CHANNELS];
    logic [COUNT_W-1:0]  match_value    [CHANNELS];
    logic [DIV_W-1:0]    prescale_sel   [CHANNELS];
    logic [PRE_W-1:0]    prescale_phase [CHANNELS];
    logic [CHANNELS-1:0] run_mask;
    logic [CHANNELS-1:0] flag_mask;
    timer_report_t       expected_reports[$];

    function automatic void step_channel(input int c);
        logic [3:0] last;
        last = 4'((4'd1 << prescale_sel[c]) - 4'd1);
        if ({1'b0, prescale_phase[c]} < last) begin
            prescale_phase[c] = prescale_phase[c] + 1'b1;
        end else begin
            prescale_phase[c] = '0;
            if (tick_count[c] == match_value[c]) begin
                tick_count[c] = '0;
                flag_mask[c]  = 1'b1;
                match_count++;
            end else begin
                tick_count[c] = tick_count[c] + 1'b1;
            end
        end
    endfunction

    function automatic timer_report_t advance_timer(input logic [2:0] act,
                                                    input logic [2:0] raw_ch,
                                                    input logic [TIME_W-1:0] t);
        timer_report_t rep;
        int            ch;
        logic [31:0]   prod;
        logic [DIV_W-1:0] sel;
        rep = '0;
        ch = (raw_ch < CHANNELS) ? int'(raw_ch) : 0;
        case (act)
            ACT_TICK: begin
                for (int c = 0; c < CHANNELS; c++)
                    if (run_mask[c]) step_channel(c);
            end
            ACT_SET: begin
                rep.status = (t == '0 || t > LIMIT_DIV8);
                sel = '0;
                if (t > LIMIT_DIV1) sel = DIV_W'(1);
                if (t > LIMIT_DIV2) sel = DIV_W'(2);
                if (t > LIMIT_DIV4) sel = DIV_W'(3);
                prod = 32'(t) * 32'(TICKS_PER_US);
                run_mask[ch]       = 1'b0;
                flag_mask[ch]      = 1'b0;
                tick_count[ch]     = '0;
                prescale_phase[ch] = '0;
                prescale_sel[ch]   = sel;
                match_value[ch]    = COUNT_W'(prod >> sel);
            end
            ACT_START: run_mask[ch]  = 1'b1;
            ACT_STOP:  run_mask[ch]  = 1'b0;
            ACT_CLEAR: flag_mask[ch] = 1'b0;
            default: ;
        endcase
        rep.flags   = flag_mask;
        rep.running = run_mask;
        return rep;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        timer_report_t want;
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                tick_count[c]     = '0;
                match_value[c]    = '1;
                prescale_sel[c]   = '0;
                prescale_phase[c] = '0;
            end
            run_mask  = '0;
            flag_mask = '0;
            expected_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                report_count++;
                if (expected_reports.size() == 0) begin
                    error_count++;
                    $display("%0t: result mismatch, expected none, got 0x%0h",
                             $time, m_tdata);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status", want.status, m_tdata[0]);
                    check_field("flags", want.flags, m_tdata[5:1]);
                    check_field("running", want.running, m_tdata[10:6]);
                end
            end
            if (s_tvalid && s_tready)
                expected_reports.push_back(advance_timer(s_tdata[2:0], s_tdata[5:3],
                                                         s_tdata[21:6]));
        end
        awaited = expected_reports.size();
    end

endmodule

// ===== tb/sv/multichannel_interval_timer_test.sv =====
module multichannel_interval_timer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mit_pkg::*;

    localparam int RANDOM_TARGET = 420;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // action[2:0], channel[5:3], time_us[21:6], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // status[0], flags[5:1], running[10:6], zero pad

    int error_count;
    int awaited;
    int report_count;
    int match_count;
    int actions_sent;
    bit src_steady;
    bit sink_steady;

    multichannel_interval_timer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    multichannel_interval_timer_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .error_count  (error_count),
        .awaited      (awaited),
        .report_count (report_count),
        .match_count  (match_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // called at a falling edge, returns at a falling edge with the transaction taken
    task automatic issue_action(input logic [2:0] act, input logic [2:0] ch,
                                input logic [15:0] t);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {2'b00, t, ch, act};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        actions_sent++;
    endtask

    task automatic issue_noise();
        issue_action(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     16'($urandom_range(0, 65535)));
    endtask

    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            int stall;
            if ($urandom_range(0, 39) == 0) sink_steady = ~sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        logic [2:0]  ch;
        logic [15:0] t;
        int          ticks;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // prescaler thresholds and invalid times, channels beyond the last one
        issue_action(ACT_SET, 3'd0, 16'd0);
        issue_action(ACT_SET, 3'd1, 16'hFFFF);
        issue_action(ACT_SET, 3'd2, 16'd1);
        issue_action(ACT_SET, 3'd3, 16'(LIMIT_DIV1));
        issue_action(ACT_SET, 3'd4, 16'(LIMIT_DIV1) + 16'd1);
        issue_action(ACT_SET, 3'd5, 16'(LIMIT_DIV2));
        issue_action(ACT_SET, 3'd6, 16'(LIMIT_DIV2) + 16'd1);
        issue_action(ACT_SET, 3'd7, 16'(LIMIT_DIV4));
        issue_action(ACT_SET, 3'd1, 16'(LIMIT_DIV4) + 16'd1);
        issue_action(ACT_SET, 3'd4, 16'(LIMIT_DIV8));
        issue_action(ACT_SET, 3'd3, 16'(LIMIT_DIV8) + 16'd1);
        issue_action(ACT_START, 3'd2, 16'hA5A5);
        issue_action(ACT_START, 3'd7, 16'h0000);
        issue_action(ACT_START, 3'd3, 16'hFFFF);
        issue_action(ACT_TICK, 3'd0, 16'h5A5A);
        issue_action(ACT_STOP, 3'd6, 16'h0000);
        issue_action(ACT_CLEAR, 3'd2, 16'h0000);
        issue_action(3'd5, 3'd1, 16'hFFFF);
        issue_action(3'd6, 3'd4, 16'h0000);
        issue_action(3'd7, 3'd7, 16'h1234);
        issue_action(ACT_START, 3'd0, 16'h0000);
        issue_action(ACT_TICK, 3'd7, 16'hFFFF);

        while (actions_sent < RANDOM_TARGET) begin
            if ($urandom_range(0, 3) == 0) src_steady = ~src_steady;
            if ($urandom_range(0, 9) < 7) begin
                ch = 3'($urandom_range(0, 7));
                t  = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(1, 4));
                issue_action(ACT_SET, ch, t);
                issue_action(ACT_START, ch, 16'($urandom_range(0, 65535)));
                ticks = $urandom_range(20, 80);
                repeat (ticks) begin
                    case ($urandom_range(0, 29))
                        0, 1: issue_action(ACT_CLEAR, 3'($urandom_range(0, 7)), '0);
                        2:    issue_action(ACT_STOP, 3'($urandom_range(0, 7)), '0);
                        3:    issue_action(ACT_START, 3'($urandom_range(0, 7)), '0);
                        4:    issue_noise();
                        default: issue_action(ACT_TICK, 3'($urandom_range(0, 7)),
                                              16'($urandom_range(0, 65535)));
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 6)) issue_noise();
            end
        end

        s_tvalid <= 1'b0;
        wait (awaited == 0);
        repeat (6) @(negedge aclk);

        $display("checked %0d timer transactions, %0d compare matches predicted",
                 report_count, match_count);
        if (error_count == 0 && awaited == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mit_pkg.sv
src/mit_channel.sv
src/multichannel_interval_timer.sv
tb/sv/multichannel_interval_timer_checker.sv
tb/sv/multichannel_interval_timer_test.sv
